### design/dual_write_quad_read_regfile_core_macros.svh
// Assertion macros for the dual-write quad-read register file.
// Included by the top level; expects clk and rst_n in scope.
`ifndef DUAL_WRITE_QUAD_READ_REGFILE_CORE_MACROS_SVH
`define DUAL_WRITE_QUAD_READ_REGFILE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DWQR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("register file check failed");
`define DWQR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("register file check failed");
`else
`define DWQR_ASSERT_SAME(label, ante, cons)
`define DWQR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/dwqr_pkg.sv
// Shared types, constants and helpers for the dual-write quad-read register file.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dwqr_pkg;

  localparam int ADDR_W      = 5;
  localparam int FIELD_W     = 32;
  localparam int NUM_PORTS   = 4;
  localparam int NUM_REGS_D  = 32;
  localparam int DATA_WIDTH_D = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_WR0,
    S_WR1
  } state_t;

  // what one read lane needs besides the data words
  typedef struct packed {
    logic              enable;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] dest0;
    logic [ADDR_W-1:0] dest1;
    logic              entry_valid;
  } lane_ctl_t;

  // nonzero register inside the bank
  function automatic logic addr_live(logic [ADDR_W-1:0] a, int num_regs);
    return (a != '0) && (int'(a) < num_regs);
  endfunction

endpackage

`default_nettype wire

### design/dual_write_quad_read_regfile_core.sv
// Dual-write quad-read register file: four bypassed read lanes over two bank copies,
// with a per-entry valid vector for reset. Depends on dwqr_pkg, dwqr_bank, dwqr_lane.
//
// Each transfer in runs through the states: the reads are issued on the accept edge into two
// bank copies of two read ports each, in S_MERGE the four lanes resolve bypass and
// load the output register once it is free, and the two write-backs then follow in S_WR0
// and S_WR1 on the write signals that both copies share. A new item is taken only after
// both write-backs, later still while a result waits in the output register. No clearing
// pass: entries never written since reset read as zero through their valid bits.
`timescale 1ns / 1ps
`default_nettype none

module dual_write_quad_read_regfile_core #(
  parameter int NUM_REGS   = dwqr_pkg::NUM_REGS_D,
  parameter int DATA_WIDTH = dwqr_pkg::DATA_WIDTH_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_port0_enable,
  input  wire logic                           in_port1_enable,
  input  wire logic                           in_port2_enable,
  input  wire logic                           in_port3_enable,
  input  wire logic [dwqr_pkg::ADDR_W-1:0]    in_port0_address,
  input  wire logic [dwqr_pkg::ADDR_W-1:0]    in_port1_address,
  input  wire logic [dwqr_pkg::ADDR_W-1:0]    in_port2_address,
  input  wire logic [dwqr_pkg::ADDR_W-1:0]    in_port3_address,
  input  wire logic [dwqr_pkg::ADDR_W-1:0]    in_lane0_dest,
  input  wire logic [dwqr_pkg::ADDR_W-1:0]    in_lane1_dest,
  input  wire logic [dwqr_pkg::FIELD_W-1:0]   in_lane0_value,
  input  wire logic [dwqr_pkg::FIELD_W-1:0]   in_lane1_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [dwqr_pkg::FIELD_W-1:0]   out_port0_data,
  output logic      [dwqr_pkg::FIELD_W-1:0]   out_port1_data,
  output logic      [dwqr_pkg::FIELD_W-1:0]   out_port2_data,
  output logic      [dwqr_pkg::FIELD_W-1:0]   out_port3_data
);

  `include "dual_write_quad_read_regfile_core_macros.svh"

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int EXT_W = (IDX_W > dwqr_pkg::ADDR_W) ? IDX_W : dwqr_pkg::ADDR_W;
  localparam int NP    = dwqr_pkg::NUM_PORTS;

  function automatic logic [IDX_W-1:0] to_idx(logic [dwqr_pkg::ADDR_W-1:0] a);
    logic [EXT_W-1:0] e;
    e = EXT_W'(a);
    return e[IDX_W-1:0];
  endfunction

  dwqr_pkg::state_t state_r, state_nxt;

  logic                          en_r   [NP];
  logic [dwqr_pkg::ADDR_W-1:0]   addr_r [NP];
  logic [dwqr_pkg::ADDR_W-1:0]   dest0_r, dest1_r;
  logic [DATA_WIDTH-1:0]         val0_r, val1_r;
  logic [NUM_REGS-1:0]           valid_r;

  logic                          en_in   [NP];
  logic [dwqr_pkg::ADDR_W-1:0]   addr_in [NP];
  logic [IDX_W-1:0]              rd_idx  [NP];
  logic [DATA_WIDTH-1:0]         rd_data [NP];
  logic [dwqr_pkg::FIELD_W-1:0]  lane_out [NP];
  logic [dwqr_pkg::FIELD_W-1:0]  out_r    [NP];
  logic                          out_valid_r;

  logic                          accept;
  logic                          out_load;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;
  logic [DATA_WIDTH-1:0]         wr_data;
  logic                          wr0_live, wr1_live;

  assign en_in[0]   = in_port0_enable;
  assign en_in[1]   = in_port1_enable;
  assign en_in[2]   = in_port2_enable;
  assign en_in[3]   = in_port3_enable;
  assign addr_in[0] = in_port0_address;
  assign addr_in[1] = in_port1_address;
  assign addr_in[2] = in_port2_address;
  assign addr_in[3] = in_port3_address;

  assign in_stall = (state_r != dwqr_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // read straight from the ports on the accept edge, else hold the captured addresses
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      rd_idx[p] = (state_r == dwqr_pkg::S_IDLE) ? to_idx(addr_in[p]) : to_idx(addr_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int p = 0; p < NP; p++) begin
        en_r[p]   <= en_in[p];
        addr_r[p] <= addr_in[p];
      end
      dest0_r <= in_lane0_dest;
      dest1_r <= in_lane1_dest;
      val0_r  <= DATA_WIDTH'(in_lane0_value);
      val1_r  <= DATA_WIDTH'(in_lane1_value);
    end
  end

  // lane 0 is dropped when lane 1 hits the same register
  assign wr1_live = dwqr_pkg::addr_live(dest1_r, NUM_REGS);
  assign wr0_live = dwqr_pkg::addr_live(dest0_r, NUM_REGS) && !(wr1_live && dest1_r == dest0_r);

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = to_idx(dest0_r);
    wr_data   = val0_r;
    case (state_r)
      dwqr_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = dwqr_pkg::S_MERGE;
        end
      end
      dwqr_pkg::S_MERGE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = dwqr_pkg::S_WR0;
        end
      end
      dwqr_pkg::S_WR0: begin
        wr_en     = wr0_live;
        state_nxt = dwqr_pkg::S_WR1;
      end
      dwqr_pkg::S_WR1: begin
        wr_en     = wr1_live;
        wr_idx    = to_idx(dest1_r);
        wr_data   = val1_r;
        state_nxt = dwqr_pkg::S_IDLE;
      end
      default: begin
        state_nxt = dwqr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwqr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  dwqr_bank #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_bank_a (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .rd_idx_a  (rd_idx[0]),
    .rd_idx_b  (rd_idx[1]),
    .rd_data_a (rd_data[0]),
    .rd_data_b (rd_data[1])
  );

  dwqr_bank #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_bank_b (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .rd_idx_a  (rd_idx[2]),
    .rd_idx_b  (rd_idx[3]),
    .rd_data_a (rd_data[2]),
    .rd_data_b (rd_data[3])
  );

  for (genvar g = 0; g < NP; g++) begin : g_lane
    dwqr_pkg::lane_ctl_t ctl;
    assign ctl.enable      = en_r[g];
    assign ctl.addr        = addr_r[g];
    assign ctl.dest0       = dest0_r;
    assign ctl.dest1       = dest1_r;
    assign ctl.entry_valid = valid_r[to_idx(addr_r[g])];

    dwqr_lane #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_lane (
      .ctl       (ctl),
      .mem_data  (rd_data[g]),
      .wb_value0 (val0_r),
      .wb_value1 (val1_r),
      .rd_data   (lane_out[g])
    );
  end

  // merge: the four lane results land together in the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int p = 0; p < NP; p++) begin
        out_r[p] <= lane_out[p];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_port0_data = out_r[0];
  assign out_port1_data = out_r[1];
  assign out_port2_data = out_r[2];
  assign out_port3_data = out_r[3];

  `DWQR_ASSERT_NEXT(a_merge_loads_out, state_r == dwqr_pkg::S_MERGE && !(out_valid_r && out_stall), out_valid_r && state_r == dwqr_pkg::S_WR0)
  `DWQR_ASSERT_SAME(a_no_write_reg0, wr_en, wr_idx != '0)
  `DWQR_ASSERT_SAME(a_reg0_never_valid, 1'b1, !valid_r[0])

endmodule

`default_nettype wire

### design/dwqr_bank.sv
// One copy of the register storage: one write port, two registered read ports.
// Depends on dwqr_pkg for defaults.
`timescale 1ns / 1ps
`default_nettype none

module dwqr_bank #(
  parameter int NUM_REGS   = dwqr_pkg::NUM_REGS_D,
  parameter int DATA_WIDTH = dwqr_pkg::DATA_WIDTH_D
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [((NUM_REGS > 1) ? $clog2(NUM_REGS) : 1)-1:0] wr_idx,
  input  wire logic [DATA_WIDTH-1:0]                         wr_data,
  input  wire logic [((NUM_REGS > 1) ? $clog2(NUM_REGS) : 1)-1:0] rd_idx_a,
  input  wire logic [((NUM_REGS > 1) ? $clog2(NUM_REGS) : 1)-1:0] rd_idx_b,
  output logic      [DATA_WIDTH-1:0]                         rd_data_a,
  output logic      [DATA_WIDTH-1:0]                         rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_idx_a];
    rd_data_b <= mem[rd_idx_b];
  end

endmodule

`default_nettype wire

### design/dwqr_lane.sv
// One read lane: port enable, register zero, range check, write bypass and entry valid bit.
// Depends on dwqr_pkg (lane_ctl_t, addr_live).
`timescale 1ns / 1ps
`default_nettype none

module dwqr_lane #(
  parameter int NUM_REGS   = dwqr_pkg::NUM_REGS_D,
  parameter int DATA_WIDTH = dwqr_pkg::DATA_WIDTH_D
) (
  input  wire dwqr_pkg::lane_ctl_t         ctl,
  input  wire logic [DATA_WIDTH-1:0]       mem_data,
  input  wire logic [DATA_WIDTH-1:0]       wb_value0,
  input  wire logic [DATA_WIDTH-1:0]       wb_value1,
  output logic      [dwqr_pkg::FIELD_W-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] res;

  always_comb begin
    if (!ctl.enable || !dwqr_pkg::addr_live(ctl.addr, NUM_REGS)) begin
      res = '0;
    end else if (dwqr_pkg::addr_live(ctl.dest1, NUM_REGS) && ctl.dest1 == ctl.addr) begin
      res = wb_value1;
    end else if (dwqr_pkg::addr_live(ctl.dest0, NUM_REGS) && ctl.dest0 == ctl.addr) begin
      res = wb_value0;
    end else if (ctl.entry_valid) begin
      res = mem_data;
    end else begin
      res = '0;  // never written since reset
    end
  end

  assign rd_data = dwqr_pkg::FIELD_W'(res);

endmodule

`default_nettype wire
